>>> rtl/gspd_pkg.sv
// ----------------------------------------------------------------------------
// gspd_pkg
// Shared types and constants for the gated stereo ping-pong delay.
// ----------------------------------------------------------------------------
package gspd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DELAY_TIME    = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [2:0] REG_ATTACK_LEN    = 3'd2;
  localparam logic [2:0] REG_RELEASE_LEN   = 3'd3;
  localparam logic [2:0] REG_TAP_GAIN      = 3'd4;
  localparam logic [2:0] REG_FOLLOW_ATTACK = 3'd5;
  localparam logic [2:0] REG_FOLLOW_RELEASE = 3'd6;
  localparam logic [2:0] REG_CONTROL_FLAGS = 3'd7;

  // mix modes
  localparam logic [1:0] MODE_MONO     = 2'd0;
  localparam logic [1:0] MODE_STEREO   = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;
  localparam logic [1:0] MODE_HARD     = 2'd3;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CFG_W    = 33;
  localparam logic [23:0] ACTIVE_THRESHOLD = 24'd8388;
  localparam logic [32:0] PHASE_ONE = 33'h1_0000_0000;
  localparam logic [4:0]  DIV_STEPS = 5'd17;

  // controller states, also the step command to the datapath
  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_ADDR, OP_RD0, OP_RD1, OP_LVL1, OP_LVL2,
    OP_I0, OP_I1, OP_I2, OP_I3, OP_I4, OP_MID,
    OP_W0, OP_W1, OP_W2, OP_W3, OP_W4, OP_WB, OP_NOP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
    logic out_free;
  } status_t;

  // saturate a wide signed value to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

>>> rtl/gated_stereo_pingpong_delay_top.sv
// ----------------------------------------------------------------------------
// gated_stereo_pingpong_delay_top
// Stereo ping-pong feedback delay with gated repeat envelope, top level.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_*       in         stereo input sample pair
// m_*       out        stereo output sample pair
// cfg_*     in         register writes, no read-back
//
// a sample pair passes through the 17-step envelope divider and the shared
// multiplier sequence; input is taken only while idle
// after reset a clearing pass writes zero to both delay lines, with s_tready
// low; config writes are accepted throughout
// a result waits in the output register; a stall on m_tready holds the
// sequencer at the commit step
// ----------------------------------------------------------------------------
module gated_stereo_pingpong_delay_top
  import gspd_pkg::*;
#(
  parameter int LINE_DEPTH = 262144
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [47:0]      s_tdata,   // right_in [47:24], left_in [23:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,   // right_out [47:24], left_out [23:0]
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic signed [23:0] out_left, out_right;

  gspd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .status(status), .cmd(cmd));

  gspd_dp #(.LINE_DEPTH(LINE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_left(s_tdata[23:0]), .in_right(s_tdata[47:24]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_left(out_left), .out_right(out_right));

  assign m_tdata = {out_right, out_left};

endmodule

>>> rtl/gspd_ram.sv
// ----------------------------------------------------------------------------
// gspd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gspd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gspd_ctrl.sv
// ----------------------------------------------------------------------------
// gspd_ctrl
// Sequencer that steps the datapath through one sample pair.
// ----------------------------------------------------------------------------
module gspd_ctrl
  import gspd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  op_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OP_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = state;
    cmd.load   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      OP_CLEAR: if (status.clear_last) state_next = OP_IDLE;
      OP_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = OP_ADDR;
        end
      end
      OP_ADDR: state_next = OP_RD0;
      OP_RD0:  state_next = OP_RD1;
      OP_RD1:  state_next = OP_LVL1;
      OP_LVL1: state_next = OP_LVL2;
      OP_LVL2: state_next = OP_I0;
      OP_I0:   state_next = OP_I1;
      OP_I1:   state_next = OP_I2;
      OP_I2:   state_next = OP_I3;
      OP_I3:   state_next = OP_I4;
      OP_I4:   state_next = OP_MID;
      OP_MID:  if (status.div_done) state_next = OP_W0;
      OP_W0:   state_next = OP_W1;
      OP_W1:   state_next = OP_W2;
      OP_W2:   state_next = OP_W3;
      OP_W3:   state_next = OP_W4;
      OP_W4:   state_next = OP_WB;
      OP_WB: begin
        if (status.out_free) begin
          state_next = OP_IDLE;
        end else begin
          cmd.op = OP_NOP;
        end
      end
      default: state_next = OP_IDLE;
    endcase
  end

  // a sample is taken only when the sequencer is idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == OP_IDLE) else $error("load outside idle");
  // wet stage starts only once the envelope divide has finished
  a_w0_div: assert property (@(posedge clk) disable iff (rst)
    state == OP_W0 |-> $past(status.div_done)) else $error("wet before divide");
  // result commit leaves the sequencer idle
  a_wb_idle: assert property (@(posedge clk) disable iff (rst)
    (state == OP_WB && status.out_free) |=> state == OP_IDLE)
    else $error("commit did not return to idle");

endmodule

>>> rtl/gspd_dp.sv
// ----------------------------------------------------------------------------
// gspd_dp
// Datapath: config registers, delay lines, shared multiplier, envelope divider.
// ----------------------------------------------------------------------------
module gspd_dp
  import gspd_pkg::*;
#(
  parameter int LINE_DEPTH = 262144
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic signed [23:0]  in_left,
  input  logic signed [23:0]  in_right,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_left,
  output logic signed [23:0]  out_right
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [29:0] SPAN = 30'(LINE_DEPTH) << 8;
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

  // configuration registers
  logic [26:0] delay_time;
  logic [32:0] phase_step;
  logic [15:0] attack_len, release_len;
  logic [16:0] tap_gain;
  logic [23:0] follow_attack_coeff, follow_release_coeff;
  logic [3:0]  control_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_time           <= 27'd6144000;
      phase_step           <= 33'd178957;
      attack_len           <= '0;
      release_len          <= '0;
      tap_gain             <= 17'd32768;
      follow_attack_coeff  <= 24'd16427336;
      follow_release_coeff <= 24'd16773720;
      control_flags        <= 4'd9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY_TIME:     delay_time           <= cfg_data[26:0];
        REG_PHASE_STEP:     phase_step           <= cfg_data[32:0];
        REG_ATTACK_LEN:     attack_len           <= cfg_data[15:0];
        REG_RELEASE_LEN:    release_len          <= cfg_data[15:0];
        REG_TAP_GAIN:       tap_gain             <= cfg_data[16:0];
        REG_FOLLOW_ATTACK:  follow_attack_coeff  <= cfg_data[23:0];
        REG_FOLLOW_RELEASE: follow_release_coeff <= cfg_data[23:0];
        REG_CONTROL_FLAGS:  control_flags        <= cfg_data[3:0];
      endcase
    end
  end

  logic [1:0] mode;
  logic       wet_only, trig_en;
  assign mode     = control_flags[1:0];
  assign wet_only = control_flags[2];
  assign trig_en  = control_flags[3];

  // control state
  logic [AW-1:0] wi;
  logic [32:0]   phase;
  logic [23:0]   level;
  logic          was_active, parity;

  // payload registers
  logic signed [23:0] inl, inr, s0l, s0r, s1l, s1r, dl, dr, dm, im, wl, wr, fbl, fbr;
  logic [23:0]        peak, rise;
  logic [29:0]        pos;
  logic signed [51:0] prod, acc;

  // delay lines
  logic          ram_we;
  logic [AW-1:0] raddr, rp0, rp1;
  logic [23:0]   wdl, wdr, rdl, rdr;

  gspd_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_ram_l (
    .clk(clk), .we(ram_we), .waddr(wi), .wdata(wdl), .raddr(raddr), .rdata(rdl));
  gspd_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_ram_r (
    .clk(clk), .we(ram_we), .waddr(wi), .wdata(wdr), .raddr(raddr), .rdata(rdr));

  logic commit;
  assign commit = cmd.op == OP_WB;
  assign ram_we = cmd.op == OP_CLEAR || commit;
  assign wdl    = (cmd.op == OP_CLEAR) ? '0 : fbl;
  assign wdr    = (cmd.op == OP_CLEAR) ? '0 : fbr;

  // read addresses from the fractional position
  assign rp0   = pos[AW+7:8];
  assign rp1   = (rp0 == LAST) ? '0 : rp0 + 1'b1;
  assign raddr = (cmd.op == OP_RD1) ? rp1 : rp0;

  logic [7:0] frac;
  logic [8:0] w0;
  assign frac = pos[7:0];
  assign w0   = 9'd256 - {1'b0, frac};

  // clamped delay and position
  logic [29:0] dt, pos_sum;
  always_comb begin
    dt = {3'b0, delay_time};
    if (dt < 30'd256) dt = 30'd256;
    if (dt > SPAN) dt = SPAN;
    pos_sum = {wi, 8'b0} + SPAN - dt;
    if (pos_sum >= SPAN) pos_sum = pos_sum - SPAN;
  end

  // peak of the input pair
  logic [23:0] abs_l, abs_r;
  assign abs_l = in_left[23]  ? 24'(-in_left)  : 24'(in_left);
  assign abs_r = in_right[23] ? 24'(-in_right) : 24'(in_right);

  // envelope divider
  logic [16:0] dq;
  logic [15:0] drem, dden;
  logic [4:0]  dcnt;
  logic        dbusy, dbypass;
  logic [16:0] dtry;
  logic        dge;
  logic [16:0] env;
  assign dtry = {drem, dq[16]};
  assign dge  = dtry >= {1'b0, dden};
  assign env  = dbypass ? 17'h10000 : dq;

  // follower update and phase restart, evaluated in the level step
  logic [23:0] level_new;
  logic        active, trig;
  logic [32:0] ph_eff, att_edge, rel_edge;
  assign level_new = (peak > level) ? rise : prod[47:24];
  assign active    = level_new > ACTIVE_THRESHOLD;
  assign trig      = trig_en && active && !was_active;
  assign ph_eff    = trig ? '0 : phase;
  assign att_edge  = {1'b0, attack_len, 16'b0};
  assign rel_edge  = PHASE_ONE - {1'b0, release_len, 16'b0};

  // operand selection for the wet and feedback products
  logic       mid_mode;
  logic signed [23:0] xa, xb, xc, xd, fba, fbb;
  always_comb begin
    mid_mode = mode == MODE_MONO || mode == MODE_HARD;
    xa = mid_mode ? dm : dl;
    xb = mid_mode ? dm : dr;
    xc = mid_mode ? dm : ((mode == MODE_PINGPONG) ? dr : dl);
    xd = mid_mode ? dm : ((mode == MODE_PINGPONG) ? dl : dr);
    fba = mid_mode ? im : inl;
    fbb = mid_mode ? im : inr;
  end

  // shared multiplier operands
  logic signed [25:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_RD0:  begin ma = {2'b0, level}; mb = {2'b0, follow_attack_coeff}; end
      OP_RD1:  begin ma = {2'b0, peak};
                     mb = 26'(25'h1000000 - {1'b0, follow_attack_coeff}); end
      OP_LVL1: begin ma = {2'b0, level}; mb = {2'b0, follow_release_coeff}; end
      OP_I0:   begin ma = 26'(s0l); mb = {17'b0, w0}; end
      OP_I1:   begin ma = 26'(s1l); mb = {18'b0, frac}; end
      OP_I2:   begin ma = 26'(s0r); mb = {17'b0, w0}; end
      OP_I3:   begin ma = 26'(s1r); mb = {18'b0, frac}; end
      OP_W0:   begin ma = 26'(xa); mb = {9'b0, env}; end
      OP_W1:   begin ma = 26'(xb); mb = {9'b0, env}; end
      OP_W2:   begin ma = 26'(xc); mb = {9'b0, tap_gain}; end
      OP_W3:   begin ma = 26'(xd); mb = {9'b0, tap_gain}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // rounded sums and products
  logic signed [52:0] sum8;
  logic signed [51:0] rnd16;
  logic signed [24:0] sum_d, sum_i;
  logic signed [27:0] fb_x, fb_y;
  logic [48:0]        sum_rise;
  assign sum8     = 53'(acc) + 53'(prod) + 53'sd128;
  assign rnd16    = (prod + 52'sd32768) >>> 16;
  assign sum_d    = 25'(dl) + 25'(dr) + 25'sd1;
  assign sum_i    = 25'(inl) + 25'(inr) + 25'sd1;
  assign fb_x     = 28'(fba) + rnd16[27:0];
  assign fb_y     = 28'(fbb) + rnd16[27:0];
  assign sum_rise = {1'b0, acc[47:0]} + {1'b0, prod[47:0]} + 49'd8388608;

  // hard ping-pong gates one side, then dry mix
  logic signed [23:0] wet_l, wet_r;
  logic signed [27:0] mix_l, mix_r;
  always_comb begin
    wet_l = wl;
    wet_r = wr;
    if (mode == MODE_HARD) begin
      wet_l = parity ? '0 : wl;
      wet_r = parity ? wl : '0;
    end
    mix_l = wet_only ? 28'(wet_l) : 28'(inl) + 28'(wet_l);
    mix_r = wet_only ? 28'(wet_r) : 28'(inr) + 28'(wet_r);
  end

  // phase advance
  logic [32:0] step;
  logic [33:0] ph_sum;
  logic        wrap;
  assign step   = (phase_step > PHASE_ONE) ? PHASE_ONE : phase_step;
  assign ph_sum = {1'b0, phase} + {1'b0, step};
  assign wrap   = ph_sum >= {1'b0, PHASE_ONE};

  // control state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      wi         <= '0;
      phase      <= '0;
      level      <= '0;
      was_active <= 1'b0;
      parity     <= 1'b0;
      dbusy      <= 1'b0;
      dcnt       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      priority case (cmd.op)
        OP_CLEAR: wi <= (wi == LAST) ? '0 : wi + 1'b1;
        OP_LVL2: begin
          level      <= level_new;
          was_active <= active;
          if (trig) begin
            phase  <= '0;
            parity <= 1'b0;
          end
          dbusy <= 1'b1;
          dcnt  <= DIV_STEPS;
        end
        OP_WB: begin
          wi        <= (wi == LAST) ? '0 : wi + 1'b1;
          phase     <= wrap ? 33'(ph_sum - {1'b0, PHASE_ONE}) : ph_sum[32:0];
          if (wrap) parity <= ~parity;
        end
        default: ;
      endcase
      if (dbusy && cmd.op != OP_LVL2) begin
        dcnt <= dcnt - 1'b1;
        if (dcnt == 5'd1) dbusy <= 1'b0;
      end
    end
  end

  // payload updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inl  <= in_left;
      inr  <= in_right;
      peak <= (abs_l > abs_r) ? abs_l : abs_r;
    end
    prod <= ma * mb;
    unique case (cmd.op)
      OP_ADDR: pos <= pos_sum;
      OP_RD1:  begin acc <= prod; s0l <= rdl; s0r <= rdr; end
      OP_LVL1: begin rise <= sum_rise[47:24]; s1l <= rdl; s1r <= rdr; end
      OP_LVL2: begin
        if (attack_len != '0 && ph_eff < att_edge) begin
          dbypass <= 1'b0;
          drem    <= ph_eff[32:17];
          dq      <= ph_eff[16:0];
          dden    <= attack_len;
        end else if (release_len != '0 && ph_eff >= rel_edge) begin
          dbypass <= 1'b0;
          drem    <= 16'((PHASE_ONE - ph_eff) >> 17);
          dq      <= 17'(PHASE_ONE - ph_eff);
          dden    <= release_len;
        end else begin
          dbypass <= 1'b1;
        end
      end
      OP_I1:   acc <= prod;
      OP_I2:   dl  <= sum8[31:8];
      OP_I3:   acc <= prod;
      OP_I4:   dr  <= sum8[31:8];
      OP_MID:  begin dm <= sum_d[24:1]; im <= sum_i[24:1]; end
      OP_W1:   wl  <= rnd16[23:0];
      OP_W2:   wr  <= rnd16[23:0];
      OP_W3:   fbl <= sat24(fb_x);
      OP_W4:   fbr <= sat24(fb_y);
      OP_WB:   begin out_left <= sat24(mix_l); out_right <= sat24(mix_r); end
      default: ;
    endcase
    if (dbusy && cmd.op != OP_LVL2) begin
      drem <= dge ? 16'(dtry - {1'b0, dden}) : dtry[15:0];
      dq   <= {dq[15:0], dge};
    end
  end

  // status back to the sequencer
  assign status.div_done   = !dbusy;
  assign status.clear_last = cmd.op == OP_CLEAR && wi == LAST;
  assign status.out_free   = !out_valid || out_ready;

  // phase stays below one full cycle
  a_phase: assert property (@(posedge clk) disable iff (rst)
    phase < PHASE_ONE) else $error("phase out of range");
  // envelope gain never exceeds unity
  a_env: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_W0) |-> env <= 17'h10000) else $error("envelope above unity");
  // a new result is never loaded over one still waiting
  a_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_WB) |-> (!out_valid || out_ready)) else $error("output overrun");

endmodule

>>> tb/sv/gated_stereo_pingpong_delay_top_tb.sv
// ----------------------------------------------------------------------------
// gated_stereo_pingpong_delay_top_tb
// Self-checking bench for the stereo ping-pong delay: a behavioral model of
// the delay lines, follower, envelope and mixer predicts every output pair,
// while random stalls on both stream sides vary the timing.
// ----------------------------------------------------------------------------
module gated_stereo_pingpong_delay_top_tb;
  import gspd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  gated_stereo_pingpong_delay_top #(.LINE_DEPTH(DEPTH)) dut (.*);

  always #1 clk = ~clk;

  // model state and registers
  longint m_delay, m_step, m_att, m_rel, m_tap, m_fa, m_fr, m_flags;
  longint line_l [DEPTH];
  longint line_r [DEPTH];
  longint wr_idx, ph, lvl, par;
  bit was_act;

  logic [47:0] pending_pairs [$];
  int mismatches = 0;
  longint cycles = 0;
  bit rx_on = 1'b0;
  int out_wait = 0;

  function automatic longint sx24(logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint rshr(longint v, int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint env_gain(longint p);
    longint one;
    one = longint'(1) << 32;
    if (m_att != 0 && p < (m_att << 16)) return p / m_att;
    if (m_rel != 0 && p >= one - (m_rel << 16)) return (one - p) / m_rel;
    return 65536;
  endfunction

  // advance the model by one sample pair and return the output pair
  function automatic logic [47:0] delay_sample(logic [47:0] din);
    longint span, one, il, ir, al, ar, pk, dt, pos, r0, r1, fr;
    longint dl, dr, e, wl, wr, fl, fr2, im, dm, w, ol, orr, st, md;
    bit act;
    span = longint'(DEPTH) << 8;
    one = longint'(1) << 32;
    il = sx24(din[23:0]);
    ir = sx24(din[47:24]);
    md = m_flags & 3;
    al = il < 0 ? -il : il;
    ar = ir < 0 ? -ir : ir;
    pk = al > ar ? al : ar;
    if (pk > lvl) lvl = (lvl * m_fa + pk * ((longint'(1) << 24) - m_fa) + (1 << 23)) >> 24;
    else lvl = (lvl * m_fr) >> 24;
    act = lvl > 8388;
    if (m_flags[3] && act && !was_act) begin
      ph = 0;
      par = 0;
    end
    was_act = act;
    dt = m_delay < 256 ? 256 : (m_delay > span ? span : m_delay);
    pos = (wr_idx << 8) + span - dt;
    if (pos >= span) pos -= span;
    r0 = (pos >> 8) % DEPTH;
    r1 = (r0 + 1) % DEPTH;
    fr = pos & 255;
    dl = rshr(line_l[r0] * (256 - fr) + line_l[r1] * fr, 8);
    dr = rshr(line_r[r0] * (256 - fr) + line_r[r1] * fr, 8);
    e = env_gain(ph);
    if (md == MODE_MONO || md == MODE_HARD) begin
      im = rshr(il + ir, 1);
      dm = rshr(dl + dr, 1);
      w = rshr(dm * e, 16);
      fl = clip24(im + rshr(dm * m_tap, 16));
      fr2 = fl;
      if (md == MODE_MONO) begin
        wl = w;
        wr = w;
      end else begin
        wl = par == 0 ? w : 0;
        wr = par != 0 ? w : 0;
      end
    end else begin
      wl = rshr(dl * e, 16);
      wr = rshr(dr * e, 16);
      if (md == MODE_PINGPONG) begin
        fl = clip24(il + rshr(dr * m_tap, 16));
        fr2 = clip24(ir + rshr(dl * m_tap, 16));
      end else begin
        fl = clip24(il + rshr(dl * m_tap, 16));
        fr2 = clip24(ir + rshr(dr * m_tap, 16));
      end
    end
    ol = clip24(m_flags[2] ? wl : il + wl);
    orr = clip24(m_flags[2] ? wr : ir + wr);
    line_l[wr_idx] = fl;
    line_r[wr_idx] = fr2;
    wr_idx = (wr_idx + 1) % DEPTH;
    st = m_step > one ? one : m_step;
    ph += st;
    if (ph >= one) begin
      ph -= one;
      par ^= 1;
    end
    return {orr[23:0], ol[23:0]};
  endfunction

  // register write, model updated alongside; the caller drops the enable
  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_DELAY_TIME: m_delay = val & 64'h7FFFFFF;
      REG_PHASE_STEP: m_step = val & 64'h1FFFFFFFF;
      REG_ATTACK_LEN: m_att = val & 64'hFFFF;
      REG_RELEASE_LEN: m_rel = val & 64'hFFFF;
      REG_TAP_GAIN: m_tap = val & 64'h1FFFF;
      REG_FOLLOW_ATTACK: m_fa = val & 64'hFFFFFF;
      REG_FOLLOW_RELEASE: m_fr = val & 64'hFFFFFF;
      default: m_flags = val & 64'hF;
    endcase
  endtask

  task automatic setup(longint dly, longint stp, longint att, longint rel, longint tap,
                       longint fa, longint fr, longint flg);
    wait (pending_pairs.size() == 0);
    repeat (40) @(posedge clk);
    write_reg(REG_DELAY_TIME, dly);
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_ATTACK_LEN, att);
    write_reg(REG_RELEASE_LEN, rel);
    write_reg(REG_TAP_GAIN, tap);
    write_reg(REG_FOLLOW_ATTACK, fa);
    write_reg(REG_FOLLOW_RELEASE, fr);
    write_reg(REG_CONTROL_FLAGS, flg);
    cfg_we <= 1'b0;
  endtask

  // one input transaction with an optional random gap ahead of it
  task automatic send_pair(logic [23:0] l, logic [23:0] r, bit gaps);
    if (gaps) repeat ($urandom_range(0, 14)) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_pairs = {pending_pairs, delay_sample({r, l})};
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 60) - 30);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic [23:0] vals [6];
    vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001, 24'h123456};
    setup(256, 64'h100000000, 0, 0, 78643, 0, 16777215, 4'b1000);
    foreach (vals[i]) send_pair(vals[i], vals[5 - i], 1'b0);
  endtask

  task automatic test_modes();
    for (int md = 0; md < 16; md++) begin
      setup(md[0] ? 0 : 300 + 37 * md, md[1] ? 64'h1FFFFFFFF : 900000000, 16384 * md[2],
            md[3] ? 32768 : 0, 65536, 16000000, 100000, md);
      for (int k = 0; k < 3; k++) send_pair(rand_sample(), rand_sample(), 1'b1);
    end
  endtask

  task automatic test_random();
    for (int ph_n = 0; ph_n < 12; ph_n++) begin
      setup(ph_n == 3 ? 64'h7FFFFFF : $urandom_range(256, DEPTH * 256 + 500),
            ph_n == 5 ? 0 : {$urandom_range(0, 1), 32'($urandom)} >> $urandom_range(0, 8),
            $urandom_range(0, 65535) >> $urandom_range(0, 3),
            $urandom_range(0, 65535) >> $urandom_range(0, 3),
            $urandom_range(0, 131071) >> $urandom_range(0, 1),
            ph_n == 7 ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF),
            ph_n == 8 ? 0 : $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 15));
      for (int k = 0; k < 70; k++) begin
        // bursts of silence let the follower fall back and retrigger
        if (k % 20 < 4) send_pair(24'h0, 24'h0, k % 3 != 0);
        else send_pair(rand_sample(), rand_sample(), $urandom_range(0, 3) != 0);
      end
    end
  endtask

  // output side: random wait per transaction and in-order checking
  always @(posedge clk) begin
    logic [47:0] exp_pair;
    cycles <= cycles + 1;
    if (m_tvalid && m_tready) begin
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction %h", m_tdata);
      end else begin
        exp_pair = pending_pairs.pop_front();
        if (exp_pair[23:0] !== m_tdata[23:0] || exp_pair[47:24] !== m_tdata[47:24]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: left exp %h act %h, right exp %h act %h", exp_pair[23:0],
                     m_tdata[23:0], exp_pair[47:24], m_tdata[47:24]);
        end
      end
      m_tready <= 1'b0;
      out_wait <= $urandom_range(0, 14);
    end else if (rx_on && m_tvalid) begin
      if (out_wait == 0) m_tready <= 1'b1;
      else out_wait <= out_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    m_delay = 6144000;
    m_step = 178957;
    m_att = 0;
    m_rel = 0;
    m_tap = 32768;
    m_fa = 16427336;
    m_fr = 16773720;
    m_flags = 9;
    foreach (line_l[i]) begin
      line_l[i] = 0;
      line_r[i] = 0;
    end
    wr_idx = 0;
    ph = 0;
    lvl = 0;
    par = 0;
    was_act = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    rx_on <= 1'b1;
    test_extremes();
    test_modes();
    test_random();
    wait (pending_pairs.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
